@@ hw/rtl/u8dv_pkg.sv @@
package u8dv_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int OUT_OFFSET_WIDTH = 32;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CONT  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_OVERLONG  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_FAILED    = 3'd6;

  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] MIN_THREE    = 21'h000800;
  localparam logic [20:0] MIN_FOUR     = 21'h010000;

  typedef struct packed {
    logic [20:0]             partial_value;
    logic [1:0]              bytes_remaining;
    logic [2:0]              sequence_length;
    logic [OFFSET_WIDTH-1:0] byte_position;
    logic [OFFSET_WIDTH-1:0] sequence_start;
    logic                    failed_flag;
  } dec_state_t;

  typedef struct packed {
    logic [20:0]                 code_point;
    logic [2:0]                  seq_size;
    logic [OUT_OFFSET_WIDTH-1:0] start_offset;
    logic [2:0]                  status;
    logic                        end_of_buffer;
  } dec_result_t;

  function automatic logic [OUT_OFFSET_WIDTH-1:0] clip_offset(
    logic [OFFSET_WIDTH-1:0] v
  );
    logic [OFFSET_WIDTH+OUT_OFFSET_WIDTH-1:0] w;
    logic [OFFSET_WIDTH+OUT_OFFSET_WIDTH-1:0] lim;
    w   = {{OUT_OFFSET_WIDTH{1'b0}}, v};
    lim = {{OFFSET_WIDTH{1'b0}}, {OUT_OFFSET_WIDTH{1'b1}}};
    if (w > lim) begin
      return {OUT_OFFSET_WIDTH{1'b1}};
    end
    return w[OUT_OFFSET_WIDTH-1:0];
  endfunction

endpackage

@@ hw/rtl/u8dv_step.sv @@
module u8dv_step import u8dv_pkg::*; (
  input  dec_state_t  st,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output dec_state_t  st_next,
  output logic        emit,
  output dec_result_t res
);

  logic [OFFSET_WIDTH-1:0] pos;
  logic [1:0]              rem;
  logic [20:0]             lead_cp;
  logic                    bad;
  logic [20:0]             cp;
  logic [2:0]              chk;

  assign pos = st.byte_position;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '0;
    rem     = 2'd0;
    lead_cp = '0;
    bad     = 1'b0;
    cp      = '0;
    chk     = ST_OK;

    if (st.failed_flag) begin
      if (last_byte) begin
        emit              = 1'b1;
        res.start_offset  = clip_offset(st.sequence_start);
        res.status        = ST_FAILED;
        res.end_of_buffer = 1'b1;
      end
    end else if (st.bytes_remaining == 2'd0) begin
      st_next.sequence_start = pos;
      if (!data_byte[7]) begin
        emit              = 1'b1;
        res.code_point    = {13'd0, data_byte};
        res.seq_size      = 3'd1;
        res.start_offset  = clip_offset(pos);
        res.status        = ST_OK;
        res.end_of_buffer = last_byte;
      end else begin
        if (data_byte[7:5] == 3'b110) begin
          rem     = 2'd1;
          lead_cp = {16'd0, data_byte[4:0]};
          bad     = data_byte < 8'hC2;
        end else if (data_byte[7:4] == 4'b1110) begin
          rem     = 2'd2;
          lead_cp = {17'd0, data_byte[3:0]};
        end else if (data_byte[7:3] == 5'b11110) begin
          rem     = 2'd3;
          lead_cp = {18'd0, data_byte[2:0]};
          bad     = data_byte > 8'hF4;
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          emit                = 1'b1;
          res.start_offset    = clip_offset(pos);
          res.status          = ST_BAD_LEAD;
          res.end_of_buffer   = last_byte;
          st_next.failed_flag = 1'b1;
        end else if (last_byte) begin
          emit              = 1'b1;
          res.start_offset  = clip_offset(pos);
          res.status        = ST_TRUNCATED;
          res.end_of_buffer = 1'b1;
        end else begin
          st_next.partial_value   = lead_cp;
          st_next.bytes_remaining = rem;
          st_next.sequence_length = {1'b0, rem} + 3'd1;
        end
      end
    end else begin
      if (last_byte && st.bytes_remaining[1]) begin
        emit              = 1'b1;
        res.start_offset  = clip_offset(st.sequence_start);
        res.status        = ST_TRUNCATED;
        res.end_of_buffer = 1'b1;
      end else if (data_byte[7:6] != 2'b10) begin
        emit                = 1'b1;
        res.start_offset    = clip_offset(st.sequence_start);
        res.status          = ST_BAD_CONT;
        res.end_of_buffer   = last_byte;
        st_next.failed_flag = 1'b1;
      end else begin
        cp                      = {st.partial_value[14:0], data_byte[5:0]};
        st_next.partial_value   = cp;
        st_next.bytes_remaining = st.bytes_remaining - 2'd1;
        if (st.bytes_remaining == 2'd1) begin
          if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
            chk = ST_RANGE;
          end else if (st.sequence_length == 3'd3 && cp < MIN_THREE) begin
            chk = ST_OVERLONG;
          end else if (st.sequence_length == 3'd4 && cp < MIN_FOUR) begin
            chk = ST_OVERLONG;
          end
          emit              = 1'b1;
          res.start_offset  = clip_offset(st.sequence_start);
          res.status        = chk;
          res.end_of_buffer = last_byte;
          if (chk == ST_OK) begin
            res.code_point = cp;
            res.seq_size   = st.sequence_length;
          end else begin
            st_next.failed_flag = 1'b1;
          end
          st_next.partial_value   = '0;
          st_next.sequence_length = '0;
        end
      end
    end

    if (last_byte) begin
      st_next = '0;
    end else if (pos != {OFFSET_WIDTH{1'b1}}) begin
      st_next.byte_position = pos + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
    end
  end

endmodule

@@ hw/rtl/utf8_stream_decoder_validator.sv @@
// UTF-8 stream decoder and validator. Bytes of a buffer enter one per item on
// data_byte, with last_byte high on the final byte. A new byte is taken every
// cycle unless byte_stall is high; an accepted byte is registered in the input
// stage and decoded there, and its result, if any, is registered into the
// output registers when that stage advances. The rate is set by the
// combinational decode step, which updates the sequence state from one byte
// to the next. Each complete well-formed sequence gives one result with its
// code point, size and start offset; lead bytes and inner continuation bytes
// give none. The first error in a buffer gives one error result, later bytes
// are dropped and the final byte, unless it held the error, reports status 6.
// A stalled result holds the decode stage, and byte_stall rises only then.
module utf8_stream_decoder_validator import u8dv_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [20:0]                 code_point,
  output logic [2:0]                  seq_size,
  output logic [OUT_OFFSET_WIDTH-1:0] start_offset,
  output logic [2:0]                  status,
  output logic                        end_of_buffer
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  dec_state_t  st;
  dec_state_t  st_next;
  logic        emit;
  dec_result_t res;
  logic        advance;

  assign advance    = s1_valid && !(result_valid && result_stall);
  assign byte_stall = s1_valid && result_valid && result_stall;

  u8dv_step u_step (
    .st        (st),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .st_next   (st_next),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      st           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (!byte_stall) begin
        s1_valid <= byte_valid;
      end
      if (advance) begin
        st           <= st_next;
        result_valid <= emit;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
    if (advance && emit) begin
      code_point    <= res.code_point;
      seq_size      <= res.seq_size;
      start_offset  <= res.start_offset;
      status        <= res.status;
      end_of_buffer <= res.end_of_buffer;
    end
  end

  a_ok_has_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK |-> seq_size != 3'd0)
    else $error("ok result without size");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> code_point == 21'd0 && seq_size == 3'd0)
    else $error("error result carries data");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> st == '0)
    else $error("state not cleared after last byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a blocked result");

endmodule
